// ===== sv/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types, sizes and helpers of the swap slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

  // Sizes
  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = 10;
  localparam int CNT_W     = 11;
  localparam int WORD_W    = 32;
  localparam int WORDS     = MAX_SLOTS / WORD_W;
  localparam int WADDR_W   = $clog2(WORDS);
  localparam int BIT_W     = $clog2(WORD_W);

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WADDR_W-1:0] waddr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_RESERVE   = 2'd2,
    OP_UNRESERVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_MISUSE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_CHK,
    ST_FREE_CHK,
    ST_REPLY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // latch the input word
    logic exec_quick;   // apply reserve or unreserve
    logic set_misuse;   // finish with misuse status
    logic rd_next;      // read the word after the current one
    logic scan_step;    // advance the scan pointer
    logic alloc_commit; // set the found bit, update counts
    logic free_commit;  // clear the slot bit, update counts
  } ssa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    alloc_pre_ok;
    logic    slot_zero;
    logic    scan_hit;
    logic    scan_last;
    logic    free_bit_set;
  } ssa_stat_t;

  // Cap the programmed total at the map size
  function automatic cnt_t eff_total(input cnt_t total);
    return (total > cnt_t'(MAX_SLOTS)) ? cnt_t'(MAX_SLOTS) : total;
  endfunction

  // Free slots, saturating at zero
  function automatic cnt_t free_calc(input cnt_t total, input cnt_t used);
    cnt_t t;
    t = eff_total(total);
    return (t > used) ? (t - used) : '0;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ssa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssa_ctrl
// Sequencer of the allocator: decodes the operation, steps the map scan and
// marks the one-cycle result.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  output logic               out_valid,
  input  ssa_pkg::ssa_stat_t stat,
  output ssa_pkg::ssa_cmd_t  cmd
);
  import ssa_pkg::*;

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.op)
          OP_ALLOC:  state_nxt = stat.alloc_pre_ok ? ST_SCAN_CHK : ST_REPLY;
          OP_FREE:   state_nxt = stat.slot_zero ? ST_REPLY : ST_FREE_CHK;
          default:   state_nxt = ST_REPLY;
        endcase
      end
      ST_SCAN_CHK: begin
        if (stat.scan_hit || stat.scan_last) state_nxt = ST_REPLY;
      end
      ST_FREE_CHK: state_nxt = ST_REPLY;
      ST_REPLY:    state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_REPLY);
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_DECODE: begin
        case (stat.op)
          OP_ALLOC: cmd.set_misuse = !stat.alloc_pre_ok;
          OP_FREE:  cmd.set_misuse = stat.slot_zero;
          default:  cmd.exec_quick = 1'b1;
        endcase
      end
      ST_SCAN_CHK: begin
        if (stat.scan_hit) begin
          cmd.alloc_commit = 1'b1;
        end else if (stat.scan_last) begin
          cmd.set_misuse = 1'b1;
        end else begin
          cmd.rd_next   = 1'b1;
          cmd.scan_step = 1'b1;
        end
      end
      ST_FREE_CHK: begin
        if (stat.free_bit_set) begin
          cmd.free_commit = 1'b1;
        end else begin
          cmd.set_misuse = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ssa_datapath.sv =====
// ----------------------------------------------------------------------------
// ssa_datapath
// Slot map memory (32-bit words with per-word valid bits), counters, the
// per-word free-bit search and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_datapath (
  input  wire                       clk,
  input  wire                       rst_n,
  input  ssa_pkg::ssa_cmd_t         cmd,
  output ssa_pkg::ssa_stat_t        stat,
  input  wire [1:0]                 in_opcode,
  input  wire [ssa_pkg::SLOT_W-1:0] in_slot_index,
  input  wire [ssa_pkg::CNT_W-1:0]  in_page_count,
  input  wire                       cfg_we,
  input  wire [ssa_pkg::CNT_W-1:0]  cfg_wdata,
  output logic [1:0]                out_status,
  output logic [ssa_pkg::SLOT_W-1:0] out_alloc_index,
  output logic [ssa_pkg::CNT_W-1:0] out_free_slots,
  output logic [ssa_pkg::CNT_W-1:0] out_reserved_slots
);
  import ssa_pkg::*;

  // Map storage
  word_t              mem_r [WORDS];
  logic [WORDS-1:0]   valid_r;
  word_t              rdata_r;

  // Latched operation and scan pointer
  opcode_t            op_r;
  logic [SLOT_W-1:0]  slot_r;
  cnt_t               n_r;
  waddr_t             word_r;

  // Counters and config
  cnt_t               used_r;
  cnt_t               res_r;
  cnt_t               total_r;

  // Result
  status_t            status_r;
  logic [SLOT_W-1:0]  alloc_r;

  // Combinational
  waddr_t             rd_addr;
  word_t              word_val;
  word_t              lim_mask;
  word_t              hits;
  logic [BIT_W-1:0]   hit_pos;
  logic [BIT_W:0]     next_base_hi;
  cnt_t               eff;
  cnt_t               free_c;
  cnt_t               avail;
  logic               mem_we;
  word_t              wdata;

  assign eff    = eff_total(total_r);
  assign free_c = free_calc(total_r, used_r);
  assign avail  = (free_c > res_r) ? (free_c - res_r) : '0;

  // Current word: a never-written word reads as its reset value
  always_comb begin
    if (valid_r[word_r]) begin
      word_val = rdata_r;
    end else if (word_r == '0) begin
      word_val = word_t'(1);
    end else begin
      word_val = '0;
    end
  end

  // Limit the search to slots below the effective total
  always_comb begin
    if (eff[CNT_W-1:BIT_W] > {1'b0, word_r}) begin
      lim_mask = '1;
    end else if (eff[CNT_W-1:BIT_W] == {1'b0, word_r}) begin
      lim_mask = (word_t'(1) << eff[BIT_W-1:0]) - word_t'(1);
    end else begin
      lim_mask = '0;
    end
  end

  assign hits = ~word_val & lim_mask;

  // Lowest clear slot in the word
  always_comb begin
    hit_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hits[i]) hit_pos = BIT_W'(i);
    end
  end

  // Last word when the next word starts at or above the total
  assign next_base_hi = {1'b0, word_r} + (BIT_W+1)'(1);

  always_comb begin
    stat              = '0;
    stat.op           = op_r;
    stat.alloc_pre_ok = (res_r != '0) && (free_c != '0);
    stat.slot_zero    = (slot_r == '0);
    stat.scan_hit     = (hits != '0);
    stat.scan_last    = ({next_base_hi, {BIT_W{1'b0}}} >= eff);
    stat.free_bit_set = word_val[slot_r[BIT_W-1:0]];
  end

  // Memory write data
  assign mem_we = cmd.alloc_commit || cmd.free_commit;
  always_comb begin
    if (cmd.alloc_commit) begin
      wdata = word_val | (word_t'(1) << hit_pos);
    end else begin
      wdata = word_val & ~(word_t'(1) << slot_r[BIT_W-1:0]);
    end
  end

  assign rd_addr = cmd.rd_next ? (word_r + waddr_t'(1)) : word_r;

  // Map memory: registered read, one write port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[rd_addr];
    if (mem_we) mem_r[word_r] <= wdata;
  end

  // Word valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[word_r] <= 1'b1;
    end
  end

  // Latch the input word, advance the scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode_t'(in_opcode);
      slot_r <= in_slot_index;
      n_r    <= in_page_count;
      word_r <= (opcode_t'(in_opcode) == OP_FREE) ? in_slot_index[SLOT_W-1:BIT_W] : '0;
    end else if (cmd.scan_step) begin
      word_r <= word_r + waddr_t'(1);
    end
  end

  // Counters and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= cnt_t'(1);
      res_r   <= '0;
      total_r <= cnt_t'(MAX_SLOTS);
    end else begin
      if (cfg_we) total_r <= cfg_wdata;
      if (cmd.alloc_commit) begin
        used_r <= used_r + cnt_t'(1);
        res_r  <= res_r - cnt_t'(1);
      end else if (cmd.free_commit) begin
        used_r <= used_r - cnt_t'(1);
      end else if (cmd.exec_quick) begin
        if (op_r == OP_RESERVE) begin
          if (n_r <= avail) res_r <= res_r + n_r;
        end else if (n_r <= res_r) begin
          res_r <= res_r - n_r;
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= STAT_OK;
      alloc_r  <= '0;
    end else if (cmd.set_misuse) begin
      status_r <= STAT_MISUSE;
    end else if (cmd.alloc_commit) begin
      alloc_r <= {word_r, hit_pos};
    end else if (cmd.exec_quick) begin
      if (op_r == OP_RESERVE) begin
        if (n_r > avail) status_r <= STAT_NOSPACE;
      end else if (n_r > res_r) begin
        status_r <= STAT_MISUSE;
      end
    end
  end

  assign out_status         = status_r;
  assign out_alloc_index    = alloc_r;
  assign out_free_slots     = free_c;
  assign out_reserved_slots = res_r;

endmodule

`default_nettype wire

// ===== sv/swap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// swap_slot_allocator
// Bitmap allocator of swap slots with a reservation count.
// ----------------------------------------------------------------------------
// A word is taken when start is high while busy is low; busy then stays high
// until the result has been shown. Each word gives exactly one result, held on
// the out_ ports for the single cycle that out_valid is high; the receiver
// cannot stall it, so it must take it then. Reserve and unreserve pass from
// decode straight to the reply; free reads the slot bit in a check state
// between them, and a free of slot 0 and an alloc with nothing reserved or
// nothing free are refused straight from decode. Any other alloc scans the
// slot map one 32-bit memory word per cycle, lowest word first, reading 1 to
// 32 words: up to the first clear slot below the total, or up to the last
// word below the total when none is clear; the single read port of the map
// memory sets this rate. Write total_slots through cfg_we/cfg_wdata only while
// busy is low. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_slot_allocator (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire [1:0]                  in_opcode,
  input  wire [ssa_pkg::SLOT_W-1:0]  in_slot_index,
  input  wire [ssa_pkg::CNT_W-1:0]   in_page_count,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [ssa_pkg::SLOT_W-1:0] out_alloc_index,
  output logic [ssa_pkg::CNT_W-1:0]  out_free_slots,
  output logic [ssa_pkg::CNT_W-1:0]  out_reserved_slots,
  input  wire                        cfg_we,
  input  wire [ssa_pkg::CNT_W-1:0]   cfg_wdata
);
  import ssa_pkg::*;

  ssa_cmd_t  cmd;
  ssa_stat_t stat;

  // Sequencer
  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Map, counters and results
  ssa_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_slot_index      (in_slot_index),
    .in_page_count      (in_page_count),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_status         (out_status),
    .out_alloc_index    (out_alloc_index),
    .out_free_slots     (out_free_slots),
    .out_reserved_slots (out_reserved_slots)
  );

endmodule

`default_nettype wire

// ===== sv/ssa_checker.sv =====
// ----------------------------------------------------------------------------
// ssa_checker
// Port-level checks of the swap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        start,
  input wire                        busy,
  input wire                        out_valid,
  input wire [1:0]                  out_status,
  input wire [ssa_pkg::SLOT_W-1:0]  out_alloc_index
);
  import ssa_pkg::*;

  // An accepted word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // A result only appears while a word is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // One result per word
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Failed operations report no slot
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_alloc_index == '0))
    else $error("slot index reported on a failed operation");

endmodule

bind swap_slot_allocator ssa_checker u_ssa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_alloc_index (out_alloc_index)
);

`default_nettype wire

// ===== bench/swap_slot_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// swap_slot_allocator_tb
// Self-checking bench for the swap slot allocator. A ledger class keeps its
// own copy of the slot map, the used and reserved counts and the total, works
// out the expected reply of each accepted word and compares every strobed
// reply with it. Stimulus is a directed pass over the corner cases followed by
// random alloc/free/reserve/unreserve traffic under several totals.
// ----------------------------------------------------------------------------

module swap_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssa_pkg::*;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct {
    status_t status;
    slot_t   alloc_index;
    cnt_t    free_slots;
    cnt_t    reserved_slots;
  } slot_reply_t;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 40;

  // Slot ledger: mirror of the allocator state and queue of expected replies
  class slot_ledger;
    bit          used_map [MAX_SLOTS];
    cnt_t        used_count;
    cnt_t        reserved_count;
    cnt_t        total;
    slot_reply_t expected_replies [$];
    int          errors;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      used_map[0]    = 1'b1;
      used_count     = 1;
      reserved_count = 0;
      total          = 1024;
      errors         = 0;
    endfunction

    function cnt_t usable();
      return (total > cnt_t'(MAX_SLOTS)) ? cnt_t'(MAX_SLOTS) : total;
    endfunction

    function cnt_t free_now();
      cnt_t t;
      t = usable();
      return (t > used_count) ? t - used_count : '0;
    endfunction

    // free slots not yet committed, saturating at zero
    function cnt_t spare();
      cnt_t f;
      f = free_now();
      return (f > reserved_count) ? f - reserved_count : '0;
    endfunction

    // random set slot other than slot 0, or 0 when none is set
    function slot_t pick_used();
      int hits;
      int k;
      slot_t pick;
      hits = 0;
      pick = '0;
      for (int i = 1; i < MAX_SLOTS; i++) if (used_map[i]) hits++;
      if (hits > 0) begin
        k = $urandom_range(hits - 1);
        for (int i = 1; i < MAX_SLOTS; i++) begin
          if (used_map[i]) begin
            if (k == 0) pick = slot_t'(i);
            k--;
          end
        end
      end
      return pick;
    endfunction

    task report(string msg);
      if (errors < 50) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Apply one accepted word and queue the reply it must produce
    function void note_word(opcode_t op, slot_t slot, cnt_t n);
      slot_reply_t r;
      cnt_t lim;
      bit found;
      r.status      = STAT_OK;
      r.alloc_index = '0;
      found         = 1'b0;
      case (op)
        OP_ALLOC: begin
          lim = usable();
          if (reserved_count != 0 && free_now() != 0) begin
            for (int i = 0; i < lim && !found; i++) begin
              if (!used_map[i]) begin
                found         = 1'b1;
                r.alloc_index = slot_t'(i);
              end
            end
          end
          if (found) begin
            used_map[r.alloc_index] = 1'b1;
            used_count++;
            reserved_count--;
          end else begin
            r.status = STAT_MISUSE;
          end
        end
        OP_FREE: begin
          if (slot == 0 || !used_map[slot]) begin
            r.status = STAT_MISUSE;
          end else begin
            used_map[slot] = 1'b0;
            used_count--;
          end
        end
        OP_RESERVE: begin
          if (n > spare()) r.status = STAT_NOSPACE;
          else reserved_count = reserved_count + n;
        end
        default: begin
          if (n > reserved_count) r.status = STAT_MISUSE;
          else reserved_count = reserved_count - n;
        end
      endcase
      r.free_slots     = free_now();
      r.reserved_slots = reserved_count;
      expected_replies.push_back(r);
    endfunction

    // Compare one strobed reply with the oldest expectation
    task check_word(logic [1:0] st, slot_t idx, cnt_t fs, cnt_t rs);
      slot_reply_t r;
      if (expected_replies.size() == 0) begin
        report("reply strobed with nothing expected");
      end else begin
        r = expected_replies.pop_front();
        if (st !== r.status)
          report($sformatf("status %0d, expected %0d", st, r.status));
        if (idx !== r.alloc_index)
          report($sformatf("alloc_index %0d, expected %0d", idx, r.alloc_index));
        if (fs !== r.free_slots)
          report($sformatf("free_slots %0d, expected %0d", fs, r.free_slots));
        if (rs !== r.reserved_slots)
          report($sformatf("reserved_slots %0d, expected %0d", rs, r.reserved_slots));
      end
    endtask
  endclass

  logic   clk           = 1'b0;
  logic   rst_n         = 1'b0;
  logic   start         = 1'b0;
  logic   [1:0] in_opcode = '0;
  slot_t  in_slot_index = '0;
  cnt_t   in_page_count = '0;
  logic   cfg_we        = 1'b0;
  cnt_t   cfg_wdata     = '0;

  logic   busy;
  logic   out_valid;
  logic   [1:0] out_status;
  slot_t  out_alloc_index;
  cnt_t   out_free_slots;
  cnt_t   out_reserved_slots;

  slot_ledger ledger;
  bit         gaps_on = 1'b1;
  int         stall_cycles = 0;

  swap_slot_allocator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_slot_index      (in_slot_index),
    .in_page_count      (in_page_count),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_alloc_index    (out_alloc_index),
    .out_free_slots     (out_free_slots),
    .out_reserved_slots (out_reserved_slots),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Check every strobed reply
  always @(posedge clk) begin
    if (rst_n && out_valid)
      ledger.check_word(out_status, out_alloc_index, out_free_slots, out_reserved_slots);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it
  task automatic send_word(opcode_t op, slot_t slot, cnt_t n);
    start         <= 1'b1;
    in_opcode     <= op;
    in_slot_index <= slot;
    in_page_count <= n;
    do @(posedge clk); while (busy);
    ledger.note_word(op, slot, n);
  endtask

  // Drop start now and then, with junk on the fields
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(99) < 8) begin
      start         <= 1'b0;
      in_opcode     <= 2'($urandom);
      in_slot_index <= slot_t'($urandom);
      in_page_count <= cnt_t'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait for the block to drain, then program a new total
  task automatic write_total(cnt_t value);
    start <= 1'b0;
    do @(posedge clk); while (ledger.expected_replies.size() != 0 || busy);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    ledger.total = value;
  endtask

  // Random traffic; alloc_pct biases toward filling the map
  task automatic run_random(int count, int alloc_pct);
    int r;
    int rest;
    int free_top;
    int rsv_top;
    opcode_t op;
    slot_t slot;
    cnt_t n;
    rest     = 94 - alloc_pct;
    free_top = 6 + alloc_pct + rest * 45 / 100;
    rsv_top  = free_top + rest * 35 / 100;
    for (int k = 0; k < count; k++) begin
      maybe_gap();
      r    = $urandom_range(99);
      slot = slot_t'($urandom);
      n    = cnt_t'($urandom_range(15));
      if (r < 6) begin
        op = opcode_t'($urandom_range(3));
        n  = cnt_t'($urandom_range(2047));
      end else if (r < 6 + alloc_pct) begin
        op = OP_ALLOC;
      end else if (r < free_top) begin
        op = OP_FREE;
        if ($urandom_range(9) != 0) slot = ledger.pick_used();
      end else if (r < rsv_top) begin
        op = OP_RESERVE;
        case ($urandom_range(3))
          0:       n = ledger.spare();
          1:       n = cnt_t'(ledger.spare() + 1);
          default: n = cnt_t'($urandom_range(8));
        endcase
      end else begin
        op = OP_UNRESERVE;
        case ($urandom_range(3))
          0:       n = ledger.reserved_count;
          1:       n = cnt_t'(ledger.reserved_count + 1);
          default: n = cnt_t'($urandom_range(ledger.reserved_count));
        endcase
      end
      send_word(op, slot, n);
    end
  endtask

  initial begin
    ledger = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Full map: misuse on an empty ledger, shortfalls, lowest-slot allocation
    write_total(1024);
    send_word(OP_ALLOC, '0, '0);
    send_word(OP_FREE, '0, '0);
    send_word(OP_FREE, 10'd1023, 11'd2047);
    send_word(OP_UNRESERVE, '0, 11'd1);
    send_word(OP_RESERVE, 10'd1023, '0);
    send_word(OP_RESERVE, '0, 11'd1024);
    send_word(OP_RESERVE, '0, 11'd2047);
    send_word(OP_RESERVE, '0, 11'd1023);
    send_word(OP_RESERVE, '0, 11'd1);
    send_word(OP_ALLOC, 10'd1023, 11'd2047);
    send_word(OP_ALLOC, '0, '0);
    send_word(OP_ALLOC, '0, '0);
    send_word(OP_FREE, 10'd2, '0);
    send_word(OP_ALLOC, '0, '0);
    send_word(OP_UNRESERVE, '0, 11'd2047);
    send_word(OP_UNRESERVE, '0, 11'd1000);
    send_word(OP_UNRESERVE, '0, '0);

    // Total shrunk below use: no free space, slots above the total still free
    write_total(2);
    send_word(OP_ALLOC, '0, '0);
    send_word(OP_RESERVE, '0, '0);
    send_word(OP_RESERVE, '0, 11'd1);
    send_word(OP_FREE, 10'd3, '0);
    send_word(OP_FREE, 10'd3, '0);
    send_word(OP_FREE, 10'd1, '0);
    send_word(OP_FREE, 10'd2, '0);
    send_word(OP_ALLOC, '0, '0);
    send_word(OP_UNRESERVE, '0, ledger.reserved_count);

    // Random traffic under a range of totals
    write_total(40);
    run_random(300, 36);
    write_total(2);
    run_random(60, 30);
    gaps_on = 1'b0;
    write_total(2047);
    run_random(150, 60);
    gaps_on = 1'b1;
    run_random(150, 60);
    repeat (3) begin
      write_total(cnt_t'($urandom_range(2, 1024)));
      run_random(100, 40);
    end
    write_total(1024);
    run_random(190, 60);

    // Drain, then hold a little longer to catch stray strobes
    start <= 1'b0;
    do @(posedge clk); while (ledger.expected_replies.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (ledger.expected_replies.size() != 0) ledger.report("expected reply never arrived");
    if (ledger.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
